[rtl/rphp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio packet header parser package
// Shared widths, codes, configuration and result types, and the helper
// functions that decode a prefix word.
// ----------------------------------------------------------------------------
package rphp_pkg;

  localparam int WordW    = 32;
  localparam int BufW     = 18;
  localparam int SizeW    = 16;
  localparam int ValueW   = 64;
  localparam int HbytesW  = 5;
  localparam int PosW     = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [SizeW-1:0] MaxWordsReset = 16'hFFFF;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBufUnder4 = 3'd1,
    StBadSize   = 3'd2,
    StBufShort  = 3'd3,
    StOverrun   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    KindPrefix   = 3'd0,
    KindStream   = 3'd1,
    KindClass    = 3'd2,
    KindIntTime  = 3'd3,
    KindFracTime = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgByteOrder = 2'd0,
    CfgMaxWords  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic             byte_order;
    logic [SizeW-1:0] max_words;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0] prefix;
    logic [PosW-1:0]  pos;
    logic             active;
    logic [WordW-1:0] half;
  } hdr_state_t;

  typedef struct packed {
    status_e             status;
    kind_e               kind;
    logic [3:0]          packet_type;
    logic                class_id_present;
    logic                trailer_present;
    logic [1:0]          tsi_kind;
    logic [1:0]          tsf_kind;
    logic [3:0]          packet_count;
    logic [SizeW-1:0]    packet_size;
    logic [ValueW-1:0]   field_value;
    logic [HbytesW-1:0]  header_bytes;
    logic                last;
  } result_t;

  // Reverses the four bytes of a word.
  function automatic logic [WordW-1:0] swap_bytes(input logic [WordW-1:0] w);
    swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Stream ID is carried by packet types 1, 3, 4 and 5.
  function automatic logic has_stream(input logic [3:0] ptype);
    has_stream = (ptype == 4'd1) || (ptype == 4'd3) || (ptype == 4'd4) ||
                 (ptype == 4'd5);
  endfunction

endpackage

[rtl/rphp_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header word decoder
// Combinational decode of one packet word against the header state: prefix
// checks, field assembly, and the next header state.
// ----------------------------------------------------------------------------
module rphp_decode (
  input  logic [rphp_pkg::WordW-1:0] raw_word_i,
  input  logic                       first_i,
  input  logic [rphp_pkg::BufW-1:0]  buffer_bytes_i,
  input  rphp_pkg::cfg_t             cfg_i,
  input  rphp_pkg::hdr_state_t       state_i,
  output logic                       has_result_o,
  output rphp_pkg::result_t          result_o,
  output rphp_pkg::hdr_state_t       state_o
);
  import rphp_pkg::*;

  logic [WordW-1:0] w;
  logic [WordW-1:0] pfx;
  logic [3:0]       n_s, n_c, n_t, n_f;
  logic [3:0]       end_s, end_c, end_t, total;
  logic [PosW-1:0]  pos_n;
  logic [3:0]       p4;
  logic             last_n;
  status_e          status;

  assign w   = cfg_i.byte_order ? swap_bytes(raw_word_i) : raw_word_i;
  assign pfx = first_i ? w : state_i.prefix;

  // Word counts of the optional fields and their running end positions.
  assign n_s   = {3'b000, has_stream(pfx[31:28])};
  assign n_c   = pfx[27] ? 4'd2 : 4'd0;
  assign n_t   = (pfx[23:22] != 2'b00) ? 4'd1 : 4'd0;
  assign n_f   = (pfx[21:20] != 2'b00) ? 4'd2 : 4'd0;
  assign end_s = n_s;
  assign end_c = end_s + n_c;
  assign end_t = end_c + n_t;
  assign total = end_t + n_f + 4'd1;

  assign pos_n  = state_i.pos + 3'd1;
  assign p4     = {1'b0, pos_n};
  assign last_n = (p4 + 4'd1) >= total;

  always_comb begin
    if (buffer_bytes_i < BufW'(4)) begin
      status = StBufUnder4;
    end else if ((w[15:0] == '0) || (w[15:0] > cfg_i.max_words)) begin
      status = StBadSize;
    end else if (buffer_bytes_i < {w[15:0], 2'b00}) begin
      status = StBufShort;
    end else if ({12'd0, total} > w[15:0]) begin
      status = StOverrun;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    has_result_o                 = 1'b0;
    state_o                      = state_i;
    result_o.status              = StOk;
    result_o.kind                = KindPrefix;
    result_o.packet_type         = pfx[31:28];
    result_o.class_id_present    = pfx[27];
    result_o.trailer_present     = (pfx[31:28] <= 4'd3) ? pfx[26] : 1'b0;
    result_o.tsi_kind            = pfx[23:22];
    result_o.tsf_kind            = pfx[21:20];
    result_o.packet_count        = pfx[19:16];
    result_o.packet_size         = pfx[15:0];
    result_o.field_value         = {32'd0, w};
    result_o.header_bytes        = {total[2:0], 2'b00};
    result_o.last                = last_n;

    if (first_i) begin
      has_result_o   = 1'b1;
      state_o.prefix = w;
      state_o.pos    = '0;
      result_o.status = status;
      if (status != StOk) begin
        state_o.active        = 1'b0;
        result_o.header_bytes = '0;
        result_o.last         = 1'b1;
      end else begin
        state_o.active = (total > 4'd1);
        result_o.last  = (total == 4'd1);
      end
    end else if (state_i.active) begin
      state_o.pos = pos_n;
      if (last_n) begin
        state_o.active = 1'b0;
      end
      if (p4 <= end_s) begin
        has_result_o  = 1'b1;
        result_o.kind = KindStream;
      end else if (p4 <= end_c) begin
        if (p4 == end_s + 4'd1) begin
          state_o.half = w;
        end else begin
          has_result_o         = 1'b1;
          result_o.kind        = KindClass;
          result_o.field_value = {8'd0, state_i.half[23:0], w};
        end
      end else if (p4 <= end_t) begin
        has_result_o  = 1'b1;
        result_o.kind = KindIntTime;
      end else begin
        if (p4 == end_t + 4'd1) begin
          state_o.half = w;
        end else begin
          has_result_o         = 1'b1;
          result_o.kind        = KindFracTime;
          result_o.field_value = cfg_i.byte_order ? {w, state_i.half}
                                                  : {state_i.half, w};
        end
      end
    end
  end

endmodule

[rtl/rphp_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded result until the receiver takes it.
// ----------------------------------------------------------------------------
module rphp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rphp_pkg::result_t result_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              busy_o,
  output rphp_pkg::result_t result_o
);
  import rphp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // The register can take a new result when empty or when it drains now.
  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

[rtl/radio_packet_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio packet header parser
// Streams packet words and reports the decoded prefix and each optional
// header field as a tagged result.
// ----------------------------------------------------------------------------
// Usage:
// Packet words enter on the input channel (in_valid_i / in_stall_o), one word
// per accepted handshake. first_i marks the prefix word; buffer_bytes_i is
// sampled with it. The prefix always yields one result carrying its status;
// stream ID, class ID, integer and fractional time fields then yield one
// result each, the last one flagged by last_o. Payload words and words seen
// outside a header are consumed silently.
// Results leave on the output channel (out_valid_o / out_stall_i) from a
// single result register, loaded at the edge that accepts the word.
// Throughput is one word per cycle; the only limit is the result register,
// so in_stall_o is high only while a held result is stalled by the receiver.
// The configuration port (cfg_valid_i / cfg_ready_o) always accepts; index 0
// selects byte order, index 1 the maximum packet size in words. Write it only
// while the parser is idle.
// Reset clears the header state, empties the result register, and restores
// big-endian words and a maximum size of 65535 words.
// ----------------------------------------------------------------------------
module radio_packet_header_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input word channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rphp_pkg::WordW-1:0]    raw_word_i,
  input  logic                          first_i,
  input  logic [rphp_pkg::BufW-1:0]     buffer_bytes_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [2:0]                    field_kind_o,
  output logic [3:0]                    packet_type_o,
  output logic                          class_id_present_o,
  output logic                          trailer_present_o,
  output logic [1:0]                    tsi_kind_o,
  output logic [1:0]                    tsf_kind_o,
  output logic [3:0]                    packet_count_o,
  output logic [rphp_pkg::SizeW-1:0]    packet_size_o,
  output logic [rphp_pkg::ValueW-1:0]   field_value_o,
  output logic [rphp_pkg::HbytesW-1:0]  header_bytes_o,
  output logic                          last_o,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rphp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rphp_pkg::CfgDataW-1:0] cfg_data_i
);
  import rphp_pkg::*;

  cfg_t       cfg_q, cfg_d;
  hdr_state_t state_q, state_next;
  logic       accept;
  logic       has_result;
  logic       out_busy;
  result_t    result_new;
  result_t    result_out;

  // Configuration registers. Writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgByteOrder: cfg_d.byte_order = cfg_data_i[0];
        CfgMaxWords:  cfg_d.max_words  = cfg_data_i[SizeW-1:0];
        default:      cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_order <= 1'b0;
      cfg_q.max_words  <= MaxWordsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A word is taken whenever the result register can accept a result.
  assign in_stall_o = out_busy;
  assign accept     = in_valid_i && !out_busy;

  rphp_decode u_decode (
    .raw_word_i     (raw_word_i),
    .first_i        (first_i),
    .buffer_bytes_i (buffer_bytes_i),
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .has_result_o   (has_result),
    .result_o       (result_new),
    .state_o        (state_next)
  );

  // Header state advances with every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_next;
    end
  end

  rphp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && has_result),
    .result_i    (result_new),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .busy_o      (out_busy),
    .result_o    (result_out)
  );

  assign status_o           = result_out.status;
  assign field_kind_o       = result_out.kind;
  assign packet_type_o      = result_out.packet_type;
  assign class_id_present_o = result_out.class_id_present;
  assign trailer_present_o  = result_out.trailer_present;
  assign tsi_kind_o         = result_out.tsi_kind;
  assign tsf_kind_o         = result_out.tsf_kind;
  assign packet_count_o     = result_out.packet_count;
  assign packet_size_o      = result_out.packet_size;
  assign field_value_o      = result_out.field_value;
  assign header_bytes_o     = result_out.header_bytes;
  assign last_o             = result_out.last;

  // An error result is always the final result of its packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StOk)) |-> last_o)
    else $error("error result without last");

  // An error result describes the prefix and reports no header length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StOk)) |->
      ((field_kind_o == KindPrefix) && (header_bytes_o == '0)))
    else $error("error result with field kind or header length");

  // The input is held back only while a result waits in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // A rejected prefix leaves no header active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && first_i && (result_new.status != StOk)) |=> !state_q.active)
    else $error("header active after a rejected prefix");

  // An accepted word that yields a result shows up on the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && has_result) |=> out_valid_o)
    else $error("result lost");

endmodule
